>>> src/flg_pkg.sv
`timescale 1ns / 1ps

package flg_pkg;

  // Default grid storage bounds.
  localparam int DEF_MAX_COLS = 64;
  localparam int DEF_MAX_ROWS = 64;

  // Size registers: width, lower clamp and reset value.
  localparam int CFG_W      = 7;
  localparam int GRID_MIN   = 3;
  localparam int GRID_RESET = 64;

  // Register indexes on the configuration port.
  localparam logic REG_GRID_WIDTH = 1'b0;
  localparam logic REG_GRID_DEPTH = 1'b1;

  // Field widths of the transfers.
  localparam int OP_W    = 2;
  localparam int POS_W   = 6;
  localparam int CELL_W  = 2;
  localparam int COUNT_W = 13;

  typedef logic [CELL_W-1:0] cell_t;

  // Cell codes.
  localparam cell_t CELL_EMPTY   = 2'd0;
  localparam cell_t CELL_TREE    = 2'd1;
  localparam cell_t CELL_BLOCKED = 2'd2;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_STEP  = 2'd2;

  // Neighbour counts that give a tree, for birth and for survival alike.
  localparam int NBR_W = 4;
  localparam logic [NBR_W-1:0] NBR_LOW  = 4'd3;
  localparam logic [NBR_W-1:0] NBR_HIGH = 4'd4;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    cell_t            cell_value;
  } cmd_item_t;

  typedef struct packed {
    cell_t              cell_state;
    logic [COUNT_W-1:0] tree_count;
  } rsp_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic sweep;
    logic out_load;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sweep_last;
  } dp_status_t;

endpackage

>>> src/flg_ctrl.sv
`timescale 1ns / 1ps

module flg_ctrl
  import flg_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  logic [OP_W-1:0] cmd_op,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output ctl_t            ctl,
  input  dp_status_t      status
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SWEEP = 2'd1;
  localparam logic [1:0] S_FIN   = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // Commands to the datapath.
  assign cmd_ready    = (state == S_IDLE);
  assign ctl.accept   = cmd_valid && cmd_ready;
  assign ctl.sweep    = (state == S_SWEEP);
  assign ctl.out_load = (state == S_FIN) && (!rsp_valid || rsp_ready);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (ctl.accept) begin
          state_next = (cmd_op == OP_STEP) ? S_SWEEP : S_FIN;
        end
      end
      S_SWEEP: begin
        if (status.sweep_last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (ctl.out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  // A generation request always starts a sweep.
  a_step_starts_sweep: assert property (@(posedge clk) disable iff (rst)
    ctl.accept && (cmd_op == OP_STEP) |=> state == S_SWEEP)
    else $error("step transfer did not start a sweep");

  // A loaded result is offered on the next cycle.
  a_load_offers: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |=> rsp_valid)
    else $error("loaded result not offered");

  // A finished result waits while the output register is still occupied.
  a_fin_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) && rsp_valid && !rsp_ready |=> state == S_FIN)
    else $error("result left while output register was full");
`endif

endmodule

>>> src/flg_datapath.sv
`timescale 1ns / 1ps

module flg_datapath
  import flg_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
)
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  cmd_item_t        cmd,
  input  ctl_t             ctl,
  output dp_status_t       status,
  output rsp_item_t        rsp
);

  localparam int CW      = $clog2(MAX_COLS);
  localparam int RW      = $clog2(MAX_ROWS);
  localparam int AW      = RW + CW;
  localparam int DEPTH   = 2 ** AW;
  localparam int TOTAL   = MAX_COLS * MAX_ROWS;
  localparam int LAST    = TOTAL + MAX_COLS + 2;
  localparam int CYW     = $clog2(LAST + 1);
  localparam int SR_LEN  = 2 * MAX_COLS + 3;
  localparam int CTR     = MAX_COLS + 1;
  localparam int CMP_W   = 9;
  localparam int WID_RST = (GRID_RESET > MAX_COLS) ? MAX_COLS : GRID_RESET;
  localparam int DEP_RST = (GRID_RESET > MAX_ROWS) ? MAX_ROWS : GRID_RESET;

  // Two ping-pong cell stores.
  cell_t bank_a [DEPTH];
  cell_t bank_b [DEPTH];
  cell_t q_a;
  cell_t q_b;
  cell_t q_sel;

  logic             cur_bank;
  logic [CFG_W-1:0] grid_width;
  logic [CFG_W-1:0] grid_depth;

  logic [CYW-1:0]     cyc;
  logic [RW-1:0]      rd_row;
  logic [CW-1:0]      rd_col;
  logic [RW-1:0]      wr_row;
  logic [CW-1:0]      wr_col;
  logic [COUNT_W-1:0] count;
  logic [OP_W-1:0]    op_reg;
  logic               in_range_reg;

  // Window line: two rows and three cells in raster order, newest at index 0.
  cell_t sr [SR_LEN];

  logic             in_range;
  logic             rd_en;
  logic             op_we;
  logic             sw_we;
  logic             we_a;
  logic             we_b;
  logic [AW-1:0]    op_addr;
  logic [AW-1:0]    raddr;
  logic [AW-1:0]    waddr;
  cell_t            op_val;
  cell_t            wdata;
  cell_t            center;
  cell_t            new_cell;
  logic [NBR_W-1:0] nbr;
  logic             interior;
  logic             in_grid;
  logic [CFG_W-1:0] cfg_hi_w;
  logic [CFG_W-1:0] cfg_hi_d;

  // Decode of a single-cell request.
  assign in_range = ({1'b0, cmd.col} < grid_width) && ({1'b0, cmd.row} < grid_depth);
  assign op_addr  = {RW'(cmd.row), CW'(cmd.col)};
  assign op_val   = (cmd.cell_value > CELL_BLOCKED) ? CELL_BLOCKED : cmd.cell_value;
  assign op_we    = ctl.accept && (cmd.op == OP_WRITE) && in_range;

  // Memory port selection: the sweep owns both ports while it runs.
  assign rd_en = (ctl.accept && (cmd.op == OP_READ)) ||
                 (ctl.sweep && (cyc < CYW'(TOTAL)));
  assign raddr = ctl.sweep ? {rd_row, rd_col} : op_addr;
  assign sw_we = ctl.sweep && (cyc >= CYW'(MAX_COLS + 3));
  assign waddr = ctl.sweep ? {wr_row, wr_col} : op_addr;
  assign wdata = ctl.sweep ? new_cell : op_val;
  assign we_a  = (op_we && !cur_bank) || (sw_we && cur_bank);
  assign we_b  = (op_we && cur_bank) || (sw_we && !cur_bank);
  assign q_sel = cur_bank ? q_b : q_a;

  assign status.sweep_last = (cyc == CYW'(LAST));

  // Bank A: one write and one registered read a cycle.
  always_ff @(posedge clk) begin
    if (we_a) begin
      bank_a[waddr] <= wdata;
    end
    if (rd_en) begin
      q_a <= bank_a[raddr];
    end
  end

  // Bank B: one write and one registered read a cycle.
  always_ff @(posedge clk) begin
    if (we_b) begin
      bank_b[waddr] <= wdata;
    end
    if (rd_en) begin
      q_b <= bank_b[raddr];
    end
  end

  // Neighbour count and the birth and survival rule at the window centre.
  assign center = sr[CTR];
  assign nbr = NBR_W'(sr[0] == CELL_TREE) + NBR_W'(sr[1] == CELL_TREE) +
               NBR_W'(sr[2] == CELL_TREE) + NBR_W'(sr[MAX_COLS] == CELL_TREE) +
               NBR_W'(sr[MAX_COLS + 2] == CELL_TREE) +
               NBR_W'(sr[2 * MAX_COLS] == CELL_TREE) +
               NBR_W'(sr[2 * MAX_COLS + 1] == CELL_TREE) +
               NBR_W'(sr[2 * MAX_COLS + 2] == CELL_TREE);
  assign interior = (CMP_W'(wr_row) >= CMP_W'(1)) &&
                    (CMP_W'(wr_row) + CMP_W'(1) < CMP_W'(grid_depth)) &&
                    (CMP_W'(wr_col) >= CMP_W'(1)) &&
                    (CMP_W'(wr_col) + CMP_W'(1) < CMP_W'(grid_width));
  assign in_grid  = (CMP_W'(wr_row) < CMP_W'(grid_depth)) &&
                    (CMP_W'(wr_col) < CMP_W'(grid_width));

  always_comb begin
    new_cell = center;
    if (interior && (center != CELL_BLOCKED)) begin
      new_cell = ((nbr == NBR_LOW) || (nbr == NBR_HIGH)) ? CELL_TREE : CELL_EMPTY;
    end
  end

  // Window line shifts one cell a cycle during a sweep.
  always_ff @(posedge clk) begin
    if (ctl.sweep) begin
      sr[0] <= q_sel;
      for (int i = 1; i < SR_LEN; i++) begin
        sr[i] <= sr[i - 1];
      end
    end
  end

  // Size registers, clamped as they are written.
  assign cfg_hi_w = (32'(cfg_data) > MAX_COLS) ? CFG_W'(MAX_COLS) : cfg_data;
  assign cfg_hi_d = (32'(cfg_data) > MAX_ROWS) ? CFG_W'(MAX_ROWS) : cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width <= CFG_W'(WID_RST);
      grid_depth <= CFG_W'(DEP_RST);
    end else if (cfg_we) begin
      if (cfg_index == REG_GRID_WIDTH) begin
        grid_width <= (cfg_data < CFG_W'(GRID_MIN)) ? CFG_W'(GRID_MIN) : cfg_hi_w;
      end else begin
        grid_depth <= (cfg_data < CFG_W'(GRID_MIN)) ? CFG_W'(GRID_MIN) : cfg_hi_d;
      end
    end
  end

  // Sweep counters, tree count and bank selection.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_bank     <= 1'b0;
      cyc          <= '0;
      rd_row       <= '0;
      rd_col       <= '0;
      wr_row       <= '0;
      wr_col       <= '0;
      count        <= '0;
      op_reg       <= OP_WRITE;
      in_range_reg <= 1'b0;
    end else if (ctl.accept) begin
      cyc          <= '0;
      rd_row       <= '0;
      rd_col       <= '0;
      wr_row       <= '0;
      wr_col       <= '0;
      count        <= '0;
      op_reg       <= cmd.op;
      in_range_reg <= in_range;
    end else if (ctl.sweep) begin
      cyc <= cyc + CYW'(1);
      if (rd_en) begin
        if (rd_col == CW'(MAX_COLS - 1)) begin
          rd_col <= '0;
          rd_row <= rd_row + RW'(1);
        end else begin
          rd_col <= rd_col + CW'(1);
        end
      end
      if (sw_we) begin
        if (wr_col == CW'(MAX_COLS - 1)) begin
          wr_col <= '0;
          wr_row <= wr_row + RW'(1);
        end else begin
          wr_col <= wr_col + CW'(1);
        end
        if (in_grid && (new_cell == CELL_TREE)) begin
          count <= count + COUNT_W'(1);
        end
      end
      if (status.sweep_last) begin
        cur_bank <= ~cur_bank;
      end
    end
  end

  // Output register, loaded when the result is handed on.
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      rsp.cell_state <= (op_reg == OP_READ) ?
                        (in_range_reg ? q_sel : CELL_BLOCKED) : CELL_EMPTY;
      rsp.tree_count <= (op_reg == OP_STEP) ? count : '0;
    end
  end

endmodule

>>> src/forest_life_generation_step_top.sv
`timescale 1ns / 1ps

// Forest life generation step. Holds a grid of empty, tree and blocked cells
// in two ping-pong stores and takes one request per transfer: write a cell,
// read a cell, or compute one generation (a tree survives, and an empty cell
// becomes a tree, with three or four tree neighbours; blocked cells and the
// outer ring are copied). Writes and reads pass through the finishing state
// into the output register once it is free. A generation sweeps the whole
// store in raster order, one cell a cycle through a single read port and a
// line buffer of two rows and three cells, whatever the sizes in use. A new
// request is taken while the previous result still waits in the output
// register. Every cell inside the grid in use must be written before the
// first generation.
module forest_life_generation_step_top
  import flg_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
)
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  cmd_item_t        cmd,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output rsp_item_t        rsp
);

  ctl_t       ctl;
  dp_status_t status;

  // Sequencer for requests and generation sweeps.
  flg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_op    (cmd.op),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .ctl       (ctl),
    .status    (status)
  );

  // Cell stores, window logic and result register.
  flg_datapath #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .ctl       (ctl),
    .status    (status),
    .rsp       (rsp)
  );

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import flg_pkg::*;

  localparam int GRID_COLS   = DEF_MAX_COLS;
  localparam int GRID_ROWS   = DEF_MAX_ROWS;
  localparam int CELLS       = GRID_COLS * GRID_ROWS;
  localparam int MAX_REPORTS = 10;
  localparam int RANDOM_ITEMS = 140;
  localparam int TAIL_CYCLES = 20;
  localparam int TIMEOUT_NS  = 4_000_000;

  // Neighbour counts that give a tree, for birth and for survival.
  localparam int TREE_NBRS_MIN = 3;
  localparam int TREE_NBRS_MAX = 4;

  // Codes that the package leaves unnamed.
  localparam logic [OP_W-1:0] OP_UNUSED      = 2'd3;
  localparam cell_t           CELL_SPARE_CODE = 2'd3;

  typedef enum int {DRAIN_FREE, DRAIN_COIN, DRAIN_SPARSE, DRAIN_BURSTY} drain_mode_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic             cfg_index = REG_GRID_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             cmd_valid = 1'b0;
  logic             cmd_ready;
  cmd_item_t        cmd = '0;
  logic             rsp_valid;
  logic             rsp_ready = 1'b0;
  rsp_item_t        rsp;

  // Predicted grid: two banks, the live one, and which cells hold a value.
  bit [CELL_W-1:0] grid_bank [2][CELLS];
  bit              cell_written [CELLS];
  bit              live_bank = 1'b0;
  int              used_cols = GRID_RESET;
  int              used_rows = GRID_RESET;
  rsp_item_t       grid_reply_q [$];

  int burst_left = 0;
  int items_sent = 0;
  int steps_sent = 0;
  int size_settings = 0;
  int results_seen = 0;
  int mismatches = 0;

  drain_mode_t drain_mode = DRAIN_FREE;
  int          drain_left = 0;

  forest_life_generation_step_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #2 clk = ~clk;

  // Size registers saturate at the minimum and at the store bounds.
  function automatic int clamp_size(input logic [CFG_W-1:0] raw, input int hi);
    int v;
    v = int'(raw);
    if (v < GRID_MIN) v = GRID_MIN;
    if (v > hi) v = hi;
    return v;
  endfunction

  // One generation from the live bank into the other, then swap and count trees.
  function automatic logic [COUNT_W-1:0] next_generation();
    bit src, dst;
    int i, r, c, dr, dc, idx, nbrs, trees;
    src = live_bank;
    dst = ~live_bank;
    for (i = 0; i < CELLS; i++) begin
      grid_bank[dst][i] = grid_bank[src][i];
    end
    for (r = 1; r + 1 < used_rows; r++) begin
      for (c = 1; c + 1 < used_cols; c++) begin
        idx = r * GRID_COLS + c;
        if (grid_bank[src][idx] != CELL_BLOCKED) begin
          nbrs = 0;
          for (dr = -1; dr <= 1; dr++) begin
            for (dc = -1; dc <= 1; dc++) begin
              if ((dr != 0 || dc != 0) &&
                  grid_bank[src][idx + dr * GRID_COLS + dc] == CELL_TREE) begin
                nbrs++;
              end
            end
          end
          grid_bank[dst][idx] = (nbrs >= TREE_NBRS_MIN && nbrs <= TREE_NBRS_MAX) ?
                                CELL_TREE : CELL_EMPTY;
        end
      end
    end
    live_bank = dst;
    trees = 0;
    for (r = 0; r < used_rows; r++) begin
      for (c = 0; c < used_cols; c++) begin
        if (grid_bank[dst][r * GRID_COLS + c] == CELL_TREE) trees++;
      end
    end
    return trees[COUNT_W-1:0];
  endfunction

  // Applies one request to the predicted grid and returns the reply it should give.
  function automatic rsp_item_t grid_apply(input cmd_item_t item);
    rsp_item_t reply;
    bit        in_grid;
    int        idx;
    reply = '0;
    in_grid = (item.col < used_cols) && (item.row < used_rows);
    idx = item.row * GRID_COLS + item.col;
    case (item.op)
      OP_WRITE: begin
        if (in_grid) begin
          grid_bank[live_bank][idx] = (item.cell_value > CELL_BLOCKED) ?
                                      CELL_BLOCKED : item.cell_value;
          cell_written[idx] = 1'b1;
        end
      end
      OP_READ: begin
        reply.cell_state = in_grid ? cell_t'(grid_bank[live_bank][idx]) : CELL_BLOCKED;
      end
      OP_STEP: begin
        reply.tree_count = next_generation();
      end
      default: begin
      end
    endcase
    return reply;
  endfunction

  function automatic void note_mismatch(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
    if (mismatches < MAX_REPORTS) begin
      $display("Mismatch on %s at %0t: expected %0d, got %0d", field, $time, want, got);
    end
    mismatches++;
  endfunction

  function automatic cell_t random_cell();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) return CELL_TREE;
    if (pick < 78) return CELL_EMPTY;
    if (pick < 92) return CELL_BLOCKED;
    return CELL_SPARE_CODE;
  endfunction

  // Mostly small sizes; now and then a value under the minimum or a large one.
  function automatic logic [CFG_W-1:0] pick_size(input bit allow_big);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return CFG_W'($urandom_range(0, 2));
    if (sel == 1 && allow_big) return CFG_W'($urandom_range(60, 127));
    return CFG_W'($urandom_range(3, 10));
  endfunction

  // Sends one request in the sender's burst pattern and records its expected reply.
  task automatic send_request(input logic [OP_W-1:0] op, input int col, input int row,
                              input cell_t value);
    cmd_item_t item;
    int        gap;
    item.op         = op;
    item.col        = col[POS_W-1:0];
    item.row        = row[POS_W-1:0];
    item.cell_value = value;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        cmd_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    cmd_valid <= 1'b1;
    cmd <= item;
    do begin
      @(posedge clk);
    end while (!cmd_ready);
    grid_reply_q.push_back(grid_apply(item));
    items_sent++;
  endtask

  task automatic step_grid();
    send_request(OP_STEP, $urandom_range(0, 63), $urandom_range(0, 63),
                 cell_t'($urandom_range(0, 3)));
    steps_sent++;
  endtask

  // Lowers valid and waits until every reply has come back.
  task automatic wait_drained();
    burst_left = 0;
    if (cmd_valid) begin
      cmd_valid <= 1'b0;
    end
    while (grid_reply_q.size() != 0) @(posedge clk);
  endtask

  // Writes both size registers while the block is idle.
  task automatic set_grid(input logic [CFG_W-1:0] width_raw, input logic [CFG_W-1:0] depth_raw);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= REG_GRID_WIDTH;
    cfg_data  <= width_raw;
    @(posedge clk);
    cfg_index <= REG_GRID_DEPTH;
    cfg_data  <= depth_raw;
    @(posedge clk);
    cfg_we <= 1'b0;
    used_cols = clamp_size(width_raw, GRID_COLS);
    used_rows = clamp_size(depth_raw, GRID_ROWS);
    size_settings++;
  endtask

  // Gives every cell of the grid in use a value before any generation.
  task automatic fill_grid();
    int r, c;
    for (r = 0; r < used_rows; r++) begin
      for (c = 0; c < used_cols; c++) begin
        if (!cell_written[r * GRID_COLS + c]) send_request(OP_WRITE, c, r, random_cell());
      end
    end
  endtask

  // Corners of the full-size grid, the spare cell code and the unused op.
  task automatic test_default_grid();
    send_request(OP_WRITE, 0, 0, CELL_TREE);
    send_request(OP_WRITE, 63, 63, CELL_SPARE_CODE);
    send_request(OP_WRITE, 63, 0, CELL_BLOCKED);
    send_request(OP_WRITE, 0, 63, CELL_EMPTY);
    send_request(OP_WRITE, 42, 21, CELL_TREE);
    send_request(OP_READ, 0, 0, CELL_EMPTY);
    send_request(OP_READ, 63, 63, CELL_EMPTY);
    send_request(OP_READ, 63, 0, CELL_SPARE_CODE);
    send_request(OP_READ, 0, 63, CELL_TREE);
    send_request(OP_READ, 42, 21, CELL_BLOCKED);
    send_request(OP_UNUSED, 63, 63, CELL_SPARE_CODE);
    send_request(OP_WRITE, 0, 0, CELL_EMPTY);
    send_request(OP_READ, 0, 0, CELL_TREE);
  endtask

  // Sizes under the minimum give a 3 by 3 grid with a single interior cell.
  task automatic test_size_clamp();
    int r, c;
    set_grid(0, 2);
    for (r = 0; r < 3; r++) begin
      for (c = 0; c < 3; c++) begin
        send_request(OP_WRITE, c, r, (r == 1 && c == 1) ? CELL_EMPTY : CELL_TREE);
      end
    end
    step_grid();
    send_request(OP_READ, 1, 1, CELL_EMPTY);
    send_request(OP_WRITE, 1, 1, CELL_TREE);
    step_grid();
    send_request(OP_READ, 1, 1, CELL_EMPTY);
    send_request(OP_READ, 3, 0, CELL_EMPTY);
    send_request(OP_READ, 0, 3, CELL_EMPTY);
    send_request(OP_READ, 63, 63, CELL_EMPTY);
    send_request(OP_WRITE, 5, 5, CELL_TREE);
  endtask

  // A hand-drawn 7 by 7 forest with births, survivals, deaths and a blocked interior.
  task automatic test_rule_cases();
    string art;
    cell_t v;
    int    r, c;
    set_grid(7, 7);
    for (r = 0; r < 7; r++) begin
      case (r)
        0: art = "TT.TB.T";
        1: art = "T.TT.TT";
        2: art = ".TBTT..";
        3: art = "TT..TT.";
        4: art = "BTT.T.T";
        5: art = ".T.TTT.";
        default: art = "T.T.BTT";
      endcase
      for (c = 0; c < 7; c++) begin
        case (art[c])
          "T": v = CELL_TREE;
          "B": v = CELL_BLOCKED;
          default: v = CELL_EMPTY;
        endcase
        send_request(OP_WRITE, c, r, v);
      end
    end
    step_grid();
    send_request(OP_READ, 2, 2, CELL_EMPTY);
    send_request(OP_READ, 3, 3, CELL_EMPTY);
    step_grid();
    send_request(OP_READ, 1, 1, CELL_EMPTY);
    send_request(OP_READ, 4, 4, CELL_EMPTY);
    send_request(OP_READ, 6, 0, CELL_EMPTY);
  endtask

  // Largest width and depth, and a write outside the grid that must leave the store alone.
  task automatic test_extreme_sizes();
    set_grid(127, 3);
    fill_grid();
    step_grid();
    send_request(OP_READ, 63, 1, CELL_EMPTY);
    send_request(OP_READ, 40, 1, CELL_EMPTY);
    send_request(OP_READ, 5, 3, CELL_EMPTY);
    step_grid();
    set_grid(3, 64);
    fill_grid();
    step_grid();
    send_request(OP_READ, 1, 63, CELL_EMPTY);
    send_request(OP_READ, 3, 10, CELL_EMPTY);
    set_grid(5, 3);
    send_request(OP_WRITE, 40, 1, CELL_SPARE_CODE);
    send_request(OP_READ, 40, 1, CELL_EMPTY);
    set_grid(64, 3);
    send_request(OP_READ, 40, 1, CELL_EMPTY);
    send_request(OP_READ, 63, 2, CELL_EMPTY);
  endtask

  // Random phases: new sizes, a fill, then a random mix of requests.
  task automatic test_random_traffic();
    int               counted, sel, n, c, r;
    bit               big_cols;
    logic [CFG_W-1:0] w, d;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      big_cols = ($urandom_range(0, 1) == 1);
      w = pick_size(big_cols);
      d = pick_size(!big_cols);
      set_grid(w, d);
      fill_grid();
      n = $urandom_range(8, 30);
      repeat (n) begin
        sel = $urandom_range(0, 99);
        if ($urandom_range(0, 9) < 7) begin
          c = $urandom_range(0, used_cols - 1);
          r = $urandom_range(0, used_rows - 1);
        end else begin
          c = $urandom_range(0, 63);
          r = $urandom_range(0, 63);
        end
        if (sel < 35) begin
          send_request(OP_WRITE, c % used_cols, r % used_rows, random_cell());
          counted++;
        end else if (sel < 42) begin
          send_request(OP_WRITE, c, r, random_cell());
        end else if (sel < 80) begin
          send_request(OP_READ, c, r, cell_t'($urandom_range(0, 3)));
          counted++;
        end else if (sel < 92) begin
          step_grid();
          counted++;
        end else begin
          send_request(OP_UNUSED, c, r, cell_t'($urandom_range(0, 3)));
        end
      end
    end
  endtask

  // Receiver: switches between stall patterns, including stretches with none.
  always @(posedge clk) begin
    if (drain_left == 0) begin
      drain_mode <= drain_mode_t'($urandom_range(0, 3));
      drain_left <= $urandom_range(10, 80);
    end else begin
      drain_left <= drain_left - 1;
    end
    case (drain_mode)
      DRAIN_FREE: rsp_ready <= 1'b1;
      DRAIN_COIN: rsp_ready <= ($urandom_range(0, 1) == 1);
      DRAIN_SPARSE: rsp_ready <= ($urandom_range(0, 5) == 0);
      default: rsp_ready <= ((drain_left % 8) < 4);
    endcase
  end

  // Each reply transfer is checked against the oldest expectation.
  always @(posedge clk) begin
    rsp_item_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      results_seen++;
      if (grid_reply_q.size() == 0) begin
        note_mismatch("unexpected reply", 32'd0, 32'(rsp));
      end else begin
        want = grid_reply_q.pop_front();
        if (rsp.cell_state !== want.cell_state) begin
          note_mismatch("cell_state", 32'(want.cell_state), 32'(rsp.cell_state));
        end
        if (rsp.tree_count !== want.tree_count) begin
          note_mismatch("tree_count", 32'(want.tree_count), 32'(rsp.tree_count));
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_default_grid();
    test_size_clamp();
    test_rule_cases();
    test_extreme_sizes();
    test_random_traffic();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d requests including %0d generations over %0d grid sizes.",
             items_sent, steps_sent, size_settings);
    $display("Checked %0d replies; %0d mismatches, %0d replies still awaited.",
             results_seen, mismatches, grid_reply_q.size());
    if (mismatches == 0 && grid_reply_q.size() == 0) begin
      $display("** forest_life_generation_step_top: PASSED **");
    end else begin
      $display("** forest_life_generation_step_top: FAILED **");
    end
    $finish;
  end

  // Hang guard.
  initial begin
    #(TIMEOUT_NS);
    $display("Timed out with %0d replies awaited.", grid_reply_q.size());
    $display("** forest_life_generation_step_top: FAILED **");
    $finish;
  end

endmodule
